// ----- design/mtlc_pkg.sv -----
// ----------------------------------------------------------------------------
// MFM track layout checker package
// Shared widths, codes, types, the saturating adder and the microcode table.
// ----------------------------------------------------------------------------
package mtlc_pkg;

    localparam int POS_W      = 24;
    localparam int SID_W      = 8;
    localparam int CODE_W     = 3;
    localparam int DLEN_W     = 15;
    localparam int STATUS_W   = 2;
    localparam int GAP_W      = 8;
    localparam int MING_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 152;
    localparam int DCNT_W     = $clog2(POS_W);
    localparam int STEP_W     = 4;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam int BASE_SECTOR_BYTES = 128;
    localparam int GAP3_MIN_BYTES    = 12;
    localparam int OPT_GAP_MAX       = 255;

    localparam int DEF_PREAMBLE_MARK_BYTES = 16;
    localparam int DEF_ID_FIELD_BYTES      = 22;
    localparam int DEF_DATA_MARK_BYTES     = 16;
    localparam int DEF_DATA_CRC_BYTES      = 2;
    localparam int DEF_BITS_PER_BYTE       = 16;
    localparam int DEF_SECTOR_LIMIT        = 32;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERLAP   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_PAST_END  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_GAP_SMALL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_INDEX      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_POST_INDEX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_ID_TO_DATA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_AFTER_DATA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BITS     = 3'd4;

    localparam logic [GAP_W-1:0] RST_GAP_INDEX      = 8'd80;
    localparam logic [GAP_W-1:0] RST_GAP_POST_INDEX = 8'd50;
    localparam logic [GAP_W-1:0] RST_GAP_ID_TO_DATA = 8'd22;
    localparam logic [GAP_W-1:0] RST_GAP_AFTER_DATA = 8'd42;
    localparam logic [POS_W-1:0] RST_TOTAL_BITS     = 24'd100000;

    typedef logic [3:0] op_t;
    localparam op_t OP_NOP    = 4'd0;
    localparam op_t OP_LOAD   = 4'd1;
    localparam op_t OP_DAM    = 4'd2;
    localparam op_t OP_DEND   = 4'd3;
    localparam op_t OP_NEXT   = 4'd4;
    localparam op_t OP_UPDATE = 4'd5;
    localparam op_t OP_SLACK  = 4'd6;
    localparam op_t OP_DIV    = 4'd7;
    localparam op_t OP_SAT    = 4'd8;
    localparam op_t OP_EMIT   = 4'd9;

    typedef logic [2:0] jcond_t;
    localparam jcond_t JC_NEVER    = 3'd0;
    localparam jcond_t JC_ALWAYS   = 3'd1;
    localparam jcond_t JC_NO_IN    = 3'd2;
    localparam jcond_t JC_NOT_LAST = 3'd3;
    localparam jcond_t JC_NO_SLACK = 3'd4;
    localparam jcond_t JC_DIV_MORE = 3'd5;
    localparam jcond_t JC_OUT_FREE = 3'd6;

    typedef logic [STEP_W-1:0] step_t;
    localparam step_t S_LOAD   = 4'd0;
    localparam step_t S_DAM    = 4'd1;
    localparam step_t S_DEND   = 4'd2;
    localparam step_t S_NEXT   = 4'd3;
    localparam step_t S_UPDATE = 4'd4;
    localparam step_t S_SLACK  = 4'd5;
    localparam step_t S_DIV    = 4'd6;
    localparam step_t S_SAT    = 4'd7;
    localparam step_t S_EMIT   = 4'd8;
    localparam step_t S_RETRY  = 4'd9;

    typedef struct packed {
        op_t    op;
        jcond_t jcond;
        step_t  target;
    } ctrl_t;

    typedef struct packed {
        logic no_in;
        logic not_last;
        logic no_slack;
        logic div_more;
        logic out_free;
    } cond_t;

    typedef struct packed {
        logic [GAP_W-1:0] gap_index;
        logic [GAP_W-1:0] gap_post_index;
        logic [GAP_W-1:0] gap_id_to_data;
        logic [GAP_W-1:0] gap_after_data;
        logic [POS_W-1:0] total_bits;
    } cfg_t;

    // Declared from the highest field down so that sector_echo lands in the low bits.
    typedef struct packed {
        logic [MING_W-1:0]   min_gap;
        logic [GAP_W-1:0]    optimal_gap;
        logic [POS_W-1:0]    used_bits;
        logic                all_readable;
        logic                fits;
        logic                readable;
        logic [STATUS_W-1:0] sector_status;
        logic [POS_W-1:0]    next_slot_pos;
        logic [POS_W-1:0]    data_end_pos;
        logic [POS_W-1:0]    data_mark_pos;
        logic [POS_W-1:0]    id_mark_pos;
        logic [SID_W-1:0]    sector_echo;
    } res_t;

    localparam int RES_BITS = $bits(res_t);

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? POS_MAX : s[POS_W-1:0];
    endfunction

    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        unique case (step)
            S_LOAD:   w = '{op: OP_LOAD,   jcond: JC_NO_IN,    target: S_LOAD};
            S_DAM:    w = '{op: OP_DAM,    jcond: JC_NEVER,    target: S_LOAD};
            S_DEND:   w = '{op: OP_DEND,   jcond: JC_NEVER,    target: S_LOAD};
            S_NEXT:   w = '{op: OP_NEXT,   jcond: JC_NEVER,    target: S_LOAD};
            S_UPDATE: w = '{op: OP_UPDATE, jcond: JC_NOT_LAST, target: S_EMIT};
            S_SLACK:  w = '{op: OP_SLACK,  jcond: JC_NO_SLACK, target: S_EMIT};
            S_DIV:    w = '{op: OP_DIV,    jcond: JC_DIV_MORE, target: S_DIV};
            S_SAT:    w = '{op: OP_SAT,    jcond: JC_NEVER,    target: S_LOAD};
            S_EMIT:   w = '{op: OP_EMIT,   jcond: JC_OUT_FREE, target: S_LOAD};
            S_RETRY:  w = '{op: OP_NOP,    jcond: JC_ALWAYS,   target: S_EMIT};
            default:  w = '{op: OP_NOP,    jcond: JC_ALWAYS,   target: S_LOAD};
        endcase
        return w;
    endfunction

endpackage

// ----- design/mfm_track_layout_checker_core.sv -----
// ----------------------------------------------------------------------------
// MFM track layout checker
// Lays out a double-density track one sector request at a time and reports
// raw bit positions, a per-sector status and, on the last sector, a summary.
//
//   Channel | Direction | Handshake           | Payload
//   s_      | in        | s_tvalid / s_tready | s_tdata, s_tlast
//   m_      | out       | m_tvalid / m_tready | m_tdata
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A sector request runs the load, mark, data end, next slot, update and emit
// steps of the microcode program; the last sector of a track adds the slack
// step and, when there is slack to divide, the bit-serial divider and clamp.
// The result sits in an output register, so the next request is taken while
// it waits; a further result waits in the emit and retry steps while m_tready is low.
// Reset returns the registers to their defaults and starts an empty track.
// ----------------------------------------------------------------------------
module mfm_track_layout_checker_core
    import mtlc_pkg::*;
#(
    parameter int PREAMBLE_MARK_BYTES = DEF_PREAMBLE_MARK_BYTES,
    parameter int ID_FIELD_BYTES      = DEF_ID_FIELD_BYTES,
    parameter int DATA_MARK_BYTES     = DEF_DATA_MARK_BYTES,
    parameter int DATA_CRC_BYTES      = DEF_DATA_CRC_BYTES,
    parameter int BITS_PER_BYTE       = DEF_BITS_PER_BYTE,
    parameter int SECTOR_LIMIT        = DEF_SECTOR_LIMIT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sector_id, size_code, data_length, zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // sector_echo, id_mark_pos, data_mark_pos, data_end_pos, next_slot_pos,
    // sector_status, readable, fits, all_readable, used_bits, optimal_gap,
    // min_gap, zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    ctrl_t ctrl;
    cond_t cond;
    res_t  m_res;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GAP_INDEX:      cfg_next.gap_index      = cfg_data[GAP_W-1:0];
                CFG_GAP_POST_INDEX: cfg_next.gap_post_index = cfg_data[GAP_W-1:0];
                CFG_GAP_ID_TO_DATA: cfg_next.gap_id_to_data = cfg_data[GAP_W-1:0];
                CFG_GAP_AFTER_DATA: cfg_next.gap_after_data = cfg_data[GAP_W-1:0];
                CFG_TOTAL_BITS:     cfg_next.total_bits     = cfg_data[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gap_index      <= RST_GAP_INDEX;
            cfg_reg.gap_post_index <= RST_GAP_POST_INDEX;
            cfg_reg.gap_id_to_data <= RST_GAP_ID_TO_DATA;
            cfg_reg.gap_after_data <= RST_GAP_AFTER_DATA;
            cfg_reg.total_bits     <= RST_TOTAL_BITS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mtlc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .ctrl    (ctrl)
    );

    mtlc_datapath #(
        .PREAMBLE_MARK_BYTES (PREAMBLE_MARK_BYTES),
        .ID_FIELD_BYTES      (ID_FIELD_BYTES),
        .DATA_MARK_BYTES     (DATA_MARK_BYTES),
        .DATA_CRC_BYTES      (DATA_CRC_BYTES),
        .BITS_PER_BYTE       (BITS_PER_BYTE),
        .SECTOR_LIMIT        (SECTOR_LIMIT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_sid    (s_tdata[SID_W-1:0]),
        .in_code   (s_tdata[SID_W+CODE_W-1:SID_W]),
        .in_dlen   (s_tdata[SID_W+CODE_W+DLEN_W-1:SID_W+CODE_W]),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .cond      (cond),
        .out_valid (m_tvalid),
        .out_res   (m_res)
    );

    assign s_tready = ctrl.op == OP_LOAD;
    assign m_tdata  = {{(M_TDATA_W - RES_BITS){1'b0}}, m_res};

    // A request is worked through before the next one is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while the previous one is in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_res.min_gap == '0 || m_res.min_gap == MING_W'(GAP3_MIN_BYTES)))
        else $error("minimum gap is neither zero nor the gap3 floor");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_res.readable == (m_res.sector_status == STAT_OK
                                         || m_res.sector_status == STAT_GAP_SMALL)))
        else $error("readable flag disagrees with sector status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_res.min_gap == '0) |-> m_res.optimal_gap == '0)
        else $error("recommended gap given without slack");

endmodule

// ----- design/mtlc_sequencer.sv -----
// ----------------------------------------------------------------------------
// MFM track layout checker sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module mtlc_sequencer
    import mtlc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cond_t cond,
    output ctrl_t ctrl
);

    step_t step_reg;
    step_t step_next;
    logic  taken;

    assign ctrl = ucode_rom(step_reg);

    always_comb begin
        unique case (ctrl.jcond)
            JC_NEVER:    taken = 1'b0;
            JC_ALWAYS:   taken = 1'b1;
            JC_NO_IN:    taken = cond.no_in;
            JC_NOT_LAST: taken = cond.not_last;
            JC_NO_SLACK: taken = cond.no_slack;
            JC_DIV_MORE: taken = cond.div_more;
            JC_OUT_FREE: taken = cond.out_free;
            default:     taken = 1'b1;
        endcase
        step_next = taken ? ctrl.target : step_reg + step_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_LOAD;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- design/mtlc_datapath.sv -----
// ----------------------------------------------------------------------------
// MFM track layout checker datapath
// Position registers, track state, a bit-serial divider and the result register.
// ----------------------------------------------------------------------------
module mtlc_datapath
    import mtlc_pkg::*;
#(
    parameter int PREAMBLE_MARK_BYTES = DEF_PREAMBLE_MARK_BYTES,
    parameter int ID_FIELD_BYTES      = DEF_ID_FIELD_BYTES,
    parameter int DATA_MARK_BYTES     = DEF_DATA_MARK_BYTES,
    parameter int DATA_CRC_BYTES      = DEF_DATA_CRC_BYTES,
    parameter int BITS_PER_BYTE       = DEF_BITS_PER_BYTE,
    parameter int SECTOR_LIMIT        = DEF_SECTOR_LIMIT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_t             ctrl,
    input  cfg_t              cfg,
    input  logic              in_valid,
    input  logic [SID_W-1:0]  in_sid,
    input  logic [CODE_W-1:0] in_code,
    input  logic [DLEN_W-1:0] in_dlen,
    input  logic              in_last,
    input  logic              out_ready,
    output cond_t             cond,
    output logic              out_valid,
    output res_t              out_res
);

    localparam int CNT_W = $clog2(SECTOR_LIMIT + 1);
    localparam int DIV_W = $clog2(SECTOR_LIMIT * BITS_PER_BYTE + 1);

    logic [SID_W-1:0]    sid_reg, sid_next;
    logic                last_reg, last_next;
    logic [DLEN_W-1:0]   len_reg, len_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    idm_reg, idm_next;
    logic [POS_W-1:0]    dam_reg, dam_next;
    logic [POS_W-1:0]    dend_reg, dend_next;
    logic [POS_W-1:0]    nxt_reg, nxt_next;
    logic [POS_W-1:0]    prev_reg, prev_next;
    logic [POS_W-1:0]    fsum_reg, fsum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                rsf_reg, rsf_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                readable_reg, readable_next;
    logic                fits_reg, fits_next;
    logic                allr_reg, allr_next;
    logic [GAP_W-1:0]    opt_reg, opt_next;
    logic [MING_W-1:0]   ming_reg, ming_next;
    logic [POS_W-1:0]    quo_reg, quo_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                out_valid_reg, out_valid_next;
    res_t                res_reg, res_next;

    logic [POS_W-1:0]    head_c, body_c, gap3_c, pre_c;
    logic [POS_W:0]      used_fixed_c;
    logic                slack_pos_c;
    logic [STATUS_W-1:0] status_c;
    logic                readable_c;
    logic [DIV_W-1:0]    dvs_c;
    logic [DIV_W:0]      trial_c;
    logic                out_free_c;

    assign head_c = POS_W'((ID_FIELD_BYTES + int'(cfg.gap_id_to_data) + DATA_MARK_BYTES)
                           * BITS_PER_BYTE);
    assign body_c = POS_W'((int'(len_reg) + DATA_CRC_BYTES) * BITS_PER_BYTE);
    assign gap3_c = POS_W'(int'(cfg.gap_after_data) * BITS_PER_BYTE);
    assign pre_c  = POS_W'((int'(cfg.gap_index) + PREAMBLE_MARK_BYTES
                            + int'(cfg.gap_post_index)) * BITS_PER_BYTE);

    assign used_fixed_c = {1'b0, pre_c} + {1'b0, fsum_reg};
    assign slack_pos_c  = {1'b0, cfg.total_bits} > used_fixed_c;

    assign dvs_c   = DIV_W'(cnt_reg * BITS_PER_BYTE);
    assign trial_c = {rem_reg, quo_reg[POS_W-1]};

    assign out_free_c = !out_valid_reg || out_ready;

    always_comb begin
        priority if (dend_reg > cfg.total_bits) begin
            status_c = STAT_PAST_END;
        end else if (cnt_reg != '0 && idm_reg < prev_reg) begin
            status_c = STAT_OVERLAP;
        end else if ((nxt_reg - dend_reg) < POS_W'(GAP3_MIN_BYTES * BITS_PER_BYTE)) begin
            status_c = STAT_GAP_SMALL;
        end else begin
            status_c = STAT_OK;
        end
        readable_c = (status_c == STAT_OK) || (status_c == STAT_GAP_SMALL);
    end

    assign cond.no_in    = !in_valid;
    assign cond.not_last = !last_reg;
    assign cond.no_slack = !slack_pos_c;
    assign cond.div_more = dcnt_reg != '0;
    assign cond.out_free = out_free_c;

    always_comb begin
        sid_next       = sid_reg;
        last_next      = last_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        idm_next       = idm_reg;
        dam_next       = dam_reg;
        dend_next      = dend_reg;
        nxt_next       = nxt_reg;
        prev_next      = prev_reg;
        fsum_next      = fsum_reg;
        cnt_next       = cnt_reg;
        rsf_next       = rsf_reg;
        status_next    = status_reg;
        readable_next  = readable_reg;
        fits_next      = fits_reg;
        allr_next      = allr_reg;
        opt_next       = opt_reg;
        ming_next      = ming_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;

        unique case (ctrl.op)
            OP_LOAD: begin
                if (in_valid) begin
                    sid_next  = in_sid;
                    last_next = in_last;
                    len_next  = (in_dlen != '0) ? in_dlen
                                                : DLEN_W'(BASE_SECTOR_BYTES << in_code);
                end
            end
            OP_DAM: begin
                // The first sector of a track starts right after the preamble.
                idm_next = (cnt_reg == '0) ? pre_c : pos_reg;
                dam_next = sat_add((cnt_reg == '0) ? pre_c : pos_reg, head_c);
            end
            OP_DEND: begin
                dend_next = sat_add(dam_reg, body_c);
            end
            OP_NEXT: begin
                nxt_next = sat_add(dend_reg, gap3_c);
            end
            OP_UPDATE: begin
                status_next   = status_c;
                readable_next = readable_c;
                rsf_next      = rsf_reg & readable_c;
                fsum_next     = sat_add(fsum_reg, head_c + body_c);
                if (cnt_reg < CNT_W'(SECTOR_LIMIT)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                prev_next = dend_reg;
                pos_next  = nxt_reg;
                fits_next = 1'b0;
                allr_next = 1'b0;
                opt_next  = '0;
                ming_next = '0;
            end
            OP_SLACK: begin
                fits_next = nxt_reg <= cfg.total_bits;
                allr_next = rsf_reg;
                quo_next  = cfg.total_bits - used_fixed_c[POS_W-1:0];
                rem_next  = '0;
                dcnt_next = DCNT_W'(POS_W - 1);
            end
            OP_DIV: begin
                // Restoring division of the slack by count times bits per byte.
                if (trial_c >= {1'b0, dvs_c}) begin
                    rem_next = DIV_W'(trial_c - {1'b0, dvs_c});
                    quo_next = {quo_reg[POS_W-2:0], 1'b1};
                end else begin
                    rem_next = trial_c[DIV_W-1:0];
                    quo_next = {quo_reg[POS_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - DCNT_W'(1);
            end
            OP_SAT: begin
                opt_next  = (quo_reg > POS_W'(OPT_GAP_MAX)) ? GAP_W'(OPT_GAP_MAX)
                                                             : quo_reg[GAP_W-1:0];
                ming_next = MING_W'(GAP3_MIN_BYTES);
            end
            OP_EMIT: begin
                if (out_free_c) begin
                    out_valid_next         = 1'b1;
                    res_next.sector_echo   = sid_reg;
                    res_next.id_mark_pos   = idm_reg;
                    res_next.data_mark_pos = dam_reg;
                    res_next.data_end_pos  = dend_reg;
                    res_next.next_slot_pos = nxt_reg;
                    res_next.sector_status = status_reg;
                    res_next.readable      = readable_reg;
                    res_next.fits          = fits_reg;
                    res_next.all_readable  = allr_reg;
                    res_next.used_bits     = nxt_reg;
                    res_next.optimal_gap   = opt_reg;
                    res_next.min_gap       = ming_reg;
                end
                if (last_reg) begin
                    prev_next = '0;
                    fsum_next = '0;
                    cnt_next  = '0;
                    rsf_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            prev_reg      <= '0;
            fsum_reg      <= '0;
            cnt_reg       <= '0;
            rsf_reg       <= 1'b1;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            prev_reg      <= prev_next;
            fsum_reg      <= fsum_next;
            cnt_reg       <= cnt_next;
            rsf_reg       <= rsf_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sid_reg      <= sid_next;
        last_reg     <= last_next;
        len_reg      <= len_next;
        idm_reg      <= idm_next;
        dam_reg      <= dam_next;
        dend_reg     <= dend_next;
        nxt_reg      <= nxt_next;
        status_reg   <= status_next;
        readable_reg <= readable_next;
        fits_reg     <= fits_next;
        allr_reg     <= allr_next;
        opt_reg      <= opt_next;
        ming_reg     <= ming_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- bench/mfm_track_layout_checker_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MFM track layout checker testbench
// Sends sector requests to the core and predicts each sector's raw bit
// positions, its status and the end-of-track summary from a shadow copy of
// the track state and the gap registers. Every result is compared field by
// field with the oldest prediction. Both stream sides stall in random bursts,
// and the gap registers are reprogrammed between tracks, extremes included.
// ----------------------------------------------------------------------------
module mfm_track_layout_checker_core_test;
    import mtlc_pkg::*;

    localparam int PREAMBLE_BYTES  = DEF_PREAMBLE_MARK_BYTES;
    localparam int ID_BYTES        = DEF_ID_FIELD_BYTES;
    localparam int DATA_MARK_BYTES = DEF_DATA_MARK_BYTES;
    localparam int CRC_BYTES       = DEF_DATA_CRC_BYTES;
    localparam int CELLS_PER_BYTE  = DEF_BITS_PER_BYTE;
    localparam int SECTOR_CAP      = DEF_SECTOR_LIMIT;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int TAIL_ITEMS    = 150;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_TOTAL_BITS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = {CFG_IDX_W{1'b1}};

    typedef struct {
        logic [SID_W-1:0]  sector_id;
        logic [CODE_W-1:0] size_code;
        logic [DLEN_W-1:0] data_length;
        logic              is_last;
    } sector_req_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the gap registers and of the track being laid out.
    cfg_t             layout_regs;
    logic [POS_W-1:0] track_pos;
    logic [POS_W-1:0] prev_end_pos;
    logic [POS_W-1:0] slot_bits_sum;
    int unsigned      sectors_on_track;
    logic             track_all_readable;

    res_t        layout_expect_q [$];
    int unsigned items_sent;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count;
    int unsigned stall_left = 0;
    bit          bursts_on;

    mfm_track_layout_checker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [POS_W-1:0] clamp_add(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > POS_MAX) ? POS_MAX : s[POS_W-1:0];
    endfunction

    function automatic longint unsigned preamble_bits_now();
        return (longint'(layout_regs.gap_index) + PREAMBLE_BYTES
                + longint'(layout_regs.gap_post_index)) * CELLS_PER_BYTE;
    endfunction

    function automatic void clear_track();
        track_pos          = POS_W'(preamble_bits_now());
        prev_end_pos       = '0;
        slot_bits_sum      = '0;
        sectors_on_track   = 0;
        track_all_readable = 1'b1;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_GAP_INDEX:      layout_regs.gap_index      = val[GAP_W-1:0];
            CFG_GAP_POST_INDEX: layout_regs.gap_post_index = val[GAP_W-1:0];
            CFG_GAP_ID_TO_DATA: layout_regs.gap_id_to_data = val[GAP_W-1:0];
            CFG_GAP_AFTER_DATA: layout_regs.gap_after_data = val[GAP_W-1:0];
            CFG_TOTAL_BITS:     layout_regs.total_bits     = val[POS_W-1:0];
            default: ;
        endcase
    endfunction

    // Lays out one sector on the shadow track and returns the result it must produce.
    function automatic res_t lay_out_sector(sector_req_t req);
        res_t            r;
        longint unsigned len;
        longint unsigned head;
        longint unsigned body;
        longint unsigned gap3_bytes;
        longint unsigned per_sector;
        longint          slack;
        r = '0;
        len = (req.data_length != 0) ? longint'(req.data_length)
                                     : (longint'(BASE_SECTOR_BYTES) << req.size_code);
        head = (ID_BYTES + longint'(layout_regs.gap_id_to_data) + DATA_MARK_BYTES)
               * CELLS_PER_BYTE;
        body = (len + CRC_BYTES) * CELLS_PER_BYTE;
        if (sectors_on_track == 0) begin
            track_pos = POS_W'(preamble_bits_now());
        end
        r.sector_echo   = req.sector_id;
        r.id_mark_pos   = track_pos;
        r.data_mark_pos = clamp_add(r.id_mark_pos, head);
        r.data_end_pos  = clamp_add(r.data_mark_pos, body);
        r.next_slot_pos = clamp_add(r.data_end_pos,
                                    longint'(layout_regs.gap_after_data) * CELLS_PER_BYTE);
        gap3_bytes = (longint'(r.next_slot_pos) - longint'(r.data_end_pos)) / CELLS_PER_BYTE;
        if (r.data_end_pos > layout_regs.total_bits) begin
            r.sector_status = STAT_PAST_END;
        end else if (sectors_on_track > 0 && r.id_mark_pos < prev_end_pos) begin
            r.sector_status = STAT_OVERLAP;
        end else if (gap3_bytes < GAP3_MIN_BYTES) begin
            r.sector_status = STAT_GAP_SMALL;
        end else begin
            r.sector_status = STAT_OK;
        end
        r.readable = (r.sector_status == STAT_OK || r.sector_status == STAT_GAP_SMALL);
        r.used_bits = r.next_slot_pos;
        slot_bits_sum = clamp_add(slot_bits_sum, clamp_add(head, body));
        if (sectors_on_track < SECTOR_CAP) begin
            sectors_on_track++;
        end
        track_all_readable = track_all_readable & r.readable;
        prev_end_pos = r.data_end_pos;
        track_pos = r.next_slot_pos;
        if (req.is_last) begin
            slack = longint'(layout_regs.total_bits) - longint'(preamble_bits_now())
                    - longint'(slot_bits_sum);
            r.fits = (r.next_slot_pos <= layout_regs.total_bits);
            r.all_readable = track_all_readable;
            if (slack > 0 && sectors_on_track > 0) begin
                per_sector = longint'(slack) / sectors_on_track / CELLS_PER_BYTE;
                r.optimal_gap = (per_sector > OPT_GAP_MAX) ? GAP_W'(OPT_GAP_MAX)
                                                           : GAP_W'(per_sector);
                r.min_gap = MING_W'(GAP3_MIN_BYTES);
            end
            clear_track();
        end
        return r;
    endfunction

    function automatic sector_req_t make_sector(logic [SID_W-1:0] sid, logic [CODE_W-1:0] code,
                                                logic [DLEN_W-1:0] dlen, logic is_last);
        sector_req_t req;
        req.sector_id   = sid;
        req.size_code   = code;
        req.data_length = dlen;
        req.is_last     = is_last;
        return req;
    endfunction

    // Mostly size-code lengths, some explicit ones, a few out of range or at the edges.
    function automatic sector_req_t random_sector(logic is_last);
        int unsigned       pick;
        logic [DLEN_W-1:0] dlen;
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
            dlen = '0;
        end else if (pick < 16) begin
            dlen = DLEN_W'($urandom_range(1, 2048));
        end else if (pick < 18) begin
            dlen = DLEN_W'($urandom);
        end else if (pick == 18) begin
            dlen = DLEN_W'(BASE_SECTOR_BYTES << 7);
        end else begin
            dlen = ($urandom_range(0, 1) == 0) ? DLEN_W'(1) : {DLEN_W{1'b1}};
        end
        return make_sector(SID_W'($urandom), CODE_W'($urandom), dlen, is_last);
    endfunction

    task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch at result %0d, %s: expected %0d, got %0d",
                     results_seen, what, want, got);
        end
    endtask

    task automatic check_field(string what, longint unsigned got, longint unsigned want);
        if (got != want) begin
            note_mismatch(what, want, got);
        end
    endtask

    task automatic compare_result(res_t want, logic [M_TDATA_W-1:0] raw);
        res_t got;
        got = raw[RES_BITS-1:0];
        check_field("sector_echo", got.sector_echo, want.sector_echo);
        check_field("id_mark_pos", got.id_mark_pos, want.id_mark_pos);
        check_field("data_mark_pos", got.data_mark_pos, want.data_mark_pos);
        check_field("data_end_pos", got.data_end_pos, want.data_end_pos);
        check_field("next_slot_pos", got.next_slot_pos, want.next_slot_pos);
        check_field("sector_status", got.sector_status, want.sector_status);
        check_field("readable", got.readable, want.readable);
        check_field("fits", got.fits, want.fits);
        check_field("all_readable", got.all_readable, want.all_readable);
        check_field("used_bits", got.used_bits, want.used_bits);
        check_field("optimal_gap", got.optimal_gap, want.optimal_gap);
        check_field("min_gap", got.min_gap, want.min_gap);
        check_field("zero fill", raw[M_TDATA_W-1:RES_BITS], 0);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (layout_expect_q.size() == 0) begin
                note_mismatch("result with no request pending, sector_echo", 0,
                              m_tdata[SID_W-1:0]);
            end else begin
                compare_result(layout_expect_q.pop_front(), m_tdata);
            end
        end
    end

    // The receiver stalls in bursts while bursts are enabled.
    always @(posedge aclk) begin
        if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            m_tready <= 1'b1;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("** mfm_track_layout_checker_core: FAILED **");
        $finish;
    end

    task automatic send_sector(sector_req_t req);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({req.data_length, req.size_code, req.sector_id});
        s_tlast  <= req.is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        layout_expect_q.push_back(lay_out_sector(req));
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (layout_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(logic [GAP_W-1:0] gap_idx, logic [GAP_W-1:0] gap_post,
                              logic [GAP_W-1:0] gap_id_data, logic [GAP_W-1:0] gap_after,
                              logic [POS_W-1:0] total, bit stray);
        logic [CFG_IDX_W-1:0]  reg_idx [$];
        logic [CFG_DATA_W-1:0] reg_val [$];
        reg_idx.push_back(CFG_GAP_INDEX);
        reg_val.push_back(CFG_DATA_W'(gap_idx));
        reg_idx.push_back(CFG_GAP_POST_INDEX);
        reg_val.push_back(CFG_DATA_W'(gap_post));
        reg_idx.push_back(CFG_GAP_ID_TO_DATA);
        reg_val.push_back(CFG_DATA_W'(gap_id_data));
        reg_idx.push_back(CFG_GAP_AFTER_DATA);
        reg_val.push_back(CFG_DATA_W'(gap_after));
        reg_idx.push_back(CFG_TOTAL_BITS);
        reg_val.push_back(CFG_DATA_W'(total));
        if (stray) begin
            reg_idx.push_front(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)));
            reg_val.push_front(CFG_DATA_W'($urandom));
        end
        foreach (reg_idx[k]) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx[k];
            cfg_data  <= reg_val[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            apply_reg_write(reg_idx[k], reg_val[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic program_random_regs();
        logic [GAP_W-1:0] gap [4];
        logic [POS_W-1:0] total;
        foreach (gap[k]) begin
            case ($urandom_range(0, 5))
                0:       gap[k] = '0;
                1:       gap[k] = '1;
                default: gap[k] = GAP_W'($urandom);
            endcase
        end
        if ($urandom_range(0, 2) == 0) begin
            gap[3] = GAP_W'($urandom_range(0, GAP3_MIN_BYTES));
        end
        case ($urandom_range(0, 9))
            0:       total = '0;
            1:       total = POS_MAX;
            2:       total = POS_W'($urandom);
            3:       total = POS_W'($urandom_range(0, 20000));
            default: total = POS_W'($urandom_range(50000, 400000));
        endcase
        write_regs(gap[0], gap[1], gap[2], gap[3], total, $urandom_range(0, 3) == 0);
    endtask

    // Every size code under the reset registers, then explicit lengths at the edges.
    task automatic test_reset_defaults();
        int k;
        for (k = 0; k < 8; k++) begin
            send_sector(make_sector((k == 7) ? 8'hFF : k[SID_W-1:0], k[CODE_W-1:0], '0,
                                    k == 7));
        end
        send_sector(make_sector(8'h00, 3'd7, 15'd1, 1'b1));
        send_sector(make_sector(8'h5A, 3'd0, 15'd16384, 1'b0));
        send_sector(make_sector(8'hA5, 3'd3, {DLEN_W{1'b1}}, 1'b1));
        wait_for_results();
    endtask

    task automatic test_short_gap3();
        write_regs(RST_GAP_INDEX, RST_GAP_POST_INDEX, RST_GAP_ID_TO_DATA, 8'd11,
                   RST_TOTAL_BITS, 1'b0);
        send_sector(make_sector(8'h01, 3'd1, '0, 1'b0));
        send_sector(make_sector(8'h02, 3'd2, '0, 1'b1));
        wait_for_results();
        write_regs(RST_GAP_INDEX, RST_GAP_POST_INDEX, RST_GAP_ID_TO_DATA, 8'd12,
                   RST_TOTAL_BITS, 1'b0);
        send_sector(make_sector(8'h03, 3'd1, '0, 1'b1));
        wait_for_results();
    endtask

    task automatic test_register_extremes();
        write_regs('0, '0, '0, '0, '0, 1'b1);
        send_sector(make_sector(8'h10, 3'd0, '0, 1'b0));
        send_sector(make_sector(8'h11, 3'd0, 15'd1, 1'b1));
        wait_for_results();
        // A single short sector on a full revolution leaves more slack than gap3 can hold.
        write_regs('1, '1, '1, '1, POS_MAX, 1'b1);
        send_sector(make_sector(8'h20, 3'd0, '0, 1'b1));
        wait_for_results();
    endtask

    // Longest sectors with widest gaps run the position into saturation and
    // send more sectors than the capped sector count.
    task automatic test_position_overflow();
        int k;
        write_regs('1, '1, '1, '1, POS_MAX, 1'b0);
        for (k = 1; k <= SECTOR_CAP + 2; k++) begin
            send_sector(make_sector(k[SID_W-1:0], 3'd7, {DLEN_W{1'b1}}, k == SECTOR_CAP + 2));
        end
        wait_for_results();
    endtask

    task automatic test_random_tracks();
        int unsigned n;
        int unsigned k;
        bit          long_track;
        while (items_sent < RANDOM_ITEMS) begin
            long_track = ($urandom_range(0, 9) == 0);
            if (long_track && $urandom_range(0, 1) == 0) begin
                // Many sectors on a full revolution divide the slack by the capped count.
                wait_for_results();
                write_regs(GAP_W'($urandom_range(0, 40)), GAP_W'($urandom_range(0, 40)),
                           GAP_W'($urandom_range(0, 40)), GAP_W'($urandom), POS_MAX, 1'b0);
            end else if ($urandom_range(0, 2) == 0) begin
                wait_for_results();
                program_random_regs();
            end
            bursts_on = ($urandom_range(0, 3) != 0);
            n = long_track ? $urandom_range(SECTOR_CAP + 1, SECTOR_CAP + 8)
                           : $urandom_range(1, 12);
            for (k = 1; k <= n; k++) begin
                send_sector(random_sector(k == n));
            end
        end
        wait_for_results();
    endtask

    task automatic test_steady_stream();
        int unsigned n;
        int unsigned k;
        bursts_on = 1'b0;
        write_regs(RST_GAP_INDEX, RST_GAP_POST_INDEX, RST_GAP_ID_TO_DATA, RST_GAP_AFTER_DATA,
                   24'd400000, 1'b0);
        while (items_sent < RANDOM_ITEMS + TAIL_ITEMS) begin
            n = $urandom_range(1, 6);
            for (k = 1; k <= n; k++) begin
                send_sector(random_sector(k == n));
            end
        end
        wait_for_results();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        items_sent     = 0;
        bursts_on      = 1'b1;
        layout_regs.gap_index      = RST_GAP_INDEX;
        layout_regs.gap_post_index = RST_GAP_POST_INDEX;
        layout_regs.gap_id_to_data = RST_GAP_ID_TO_DATA;
        layout_regs.gap_after_data = RST_GAP_AFTER_DATA;
        layout_regs.total_bits     = RST_TOTAL_BITS;
        clear_track();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_short_gap3();
        test_register_extremes();
        test_position_overflow();
        test_random_tracks();
        test_steady_stream();

        if (mismatch_count == 0) begin
            $display("** mfm_track_layout_checker_core: PASSED **");
        end else begin
            $display("** mfm_track_layout_checker_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/mtlc_pkg.sv
design/mtlc_sequencer.sv
design/mtlc_datapath.sv
design/mfm_track_layout_checker_core.sv
bench/mfm_track_layout_checker_core_test.sv
